// ----- hdl/tpo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpo_pkg
// Shared widths, register indexes, input action codes and drive state
// codes for the time-proportioning output block.
// ----------------------------------------------------------------------------
package tpo_pkg;

  // time stamps and second-valued registers
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_TIME_W = 16;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DRIVE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_POWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT    = 3'd4;

  // input actions
  localparam logic ACTION_TICK      = 1'b0;
  localparam logic ACTION_SET_POWER = 1'b1;

  // drive state codes
  localparam int unsigned DRIVE_W = 2;
  localparam logic [DRIVE_W-1:0] DRIVE_OFF     = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_ON      = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_UNKNOWN = 2'd2;

endpackage

// ----- hdl/tpo_rem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpo_rem
// Serial restoring remainder unit: time stamp modulo cycle length,
// one quotient bit per clock.
// ----------------------------------------------------------------------------
module tpo_rem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tpo_pkg::TIME_W-1:0]      dividend_i,
  input  logic [tpo_pkg::CFG_TIME_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [tpo_pkg::CFG_TIME_W-1:0]  rem_o
);
  import tpo_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0]     num_q;
  logic [CFG_TIME_W-1:0] dvs_q;
  logic [CFG_TIME_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [CFG_TIME_W:0]   trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, num_q[TIME_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = CFG_TIME_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[CFG_TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(TIME_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[TIME_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/tpo_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpo_mac
// Shared signed multiply-accumulate unit for the effective power term.
// ----------------------------------------------------------------------------
module tpo_mac #(
  parameter int unsigned A_W = 19,
  parameter int unsigned B_W = 17
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        clr_i,
  input  logic signed [A_W-1:0]       op_a_i,
  input  logic signed [B_W-1:0]       op_b_i,
  output logic signed [A_W+B_W-1:0]   acc_o
);
  import tpo_pkg::*;

  logic signed [A_W+B_W-1:0] acc_q, acc_d;

  // keep every operand signed so a negative product extends correctly
  always_comb begin
    if (clr_i) begin
      acc_d = op_a_i * op_b_i;
    end else begin
      acc_d = acc_q + (op_a_i * op_b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- hdl/time_proportioning_output.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_proportioning_output
// Time-proportioning on/off drive: turns a power demand into a switched
// drive over a fixed cycle, with stale-demand fallback and dead-time
// correction. Emits a transaction only when the drive changes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  -------------------------------
//  in        in         in_valid_i/in_ready_o  action, now_seconds, power_demand
//  out       out        out_valid_o/out_ready_i drive_level, fallback_used
//  cfg       in         cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
//  A set_power transaction leaves in_ready_o high, so set_power requests can
//  be taken back to back. A tick holds in_ready_o low after its accept until
//  its sequence ends: the serial remainder unit works through the time stamp
//  bit by bit and raises its done flag, then come two passes through the
//  shared MAC and the compare step. Reset clears all control state and loads
//  register defaults; the drive state starts unknown. A result that is not
//  taken holds in the output register; a tick that needs to emit while it is
//  still full waits in the compare step.
//
module time_proportioning_output #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input transactions
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   action_i,
  input  logic [tpo_pkg::TIME_W-1:0]             now_seconds_i,
  input  logic [FRACTION_BITS:0]                 power_demand_i,
  // result transactions
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   drive_level_o,
  output logic                                   fallback_used_o,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [tpo_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [((FRACTION_BITS >= 16) ? FRACTION_BITS : 15):0] cfg_wdata_i
);
  import tpo_pkg::*;

  // power width, MAC operand and accumulator widths
  localparam int unsigned PW   = FRACTION_BITS + 1;
  localparam int unsigned MA_W = PW + 2;
  localparam int unsigned MB_W = CFG_TIME_W + 1;
  localparam int unsigned AW   = MA_W + MB_W;
  localparam logic [PW-1:0] FullPower = PW'(1) << FRACTION_BITS;

  // sequencer codes
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_DIV    = 3'd1;
  localparam logic [ST_W-1:0] ST_MUL_PC = 3'd2;
  localparam logic [ST_W-1:0] ST_MUL_DT = 3'd3;
  localparam logic [ST_W-1:0] ST_CMP    = 3'd4;

  // configuration registers
  logic [CFG_TIME_W-1:0] cycle_len_q;
  logic [CFG_TIME_W-1:0] dead_time_q;
  logic                  invert_q;
  logic [PW-1:0]         fallback_q;
  logic [CFG_TIME_W-1:0] stale_lim_q;

  // block state
  logic [PW-1:0]         power_q;
  logic [TIME_W-1:0]     last_time_q;
  logic [DRIVE_W-1:0]    drive_q;

  // sequencer and work registers
  logic [ST_W-1:0]       state_q, state_d;
  logic                  fb_used_q;

  // output register
  logic                  out_valid_q;
  logic                  drive_level_q;
  logic                  fallback_used_q;

  logic                  in_fire;
  logic [TIME_W-1:0]     elapsed;
  logic                  stale;
  logic [PW-1:0]         demand_sat;
  logic [PW-1:0]         fallback_sat;
  logic [CFG_TIME_W-1:0] cycle_eff;

  logic                  rem_start;
  logic                  rem_done;
  logic [CFG_TIME_W-1:0] phase;

  logic                  mac_en;
  logic                  mac_clr;
  logic signed [MA_W-1:0] mac_a;
  logic signed [MB_W-1:0] mac_b;
  logic signed [AW-1:0]  eff;
  logic                  dt_apply;

  logic signed [AW-1:0]  full_scaled;
  logic signed [AW-1:0]  wave;
  logic                  rising;
  logic [DRIVE_W-1:0]    drive_next;
  logic                  drive_change;
  logic                  out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // a zero cycle length counts as one second
  assign cycle_eff = (cycle_len_q == '0) ? CFG_TIME_W'(1) : cycle_len_q;

  // saturate powers to full scale when they are stored
  always_comb begin
    demand_sat   = (power_demand_i > FullPower) ? FullPower : power_demand_i;
    fallback_sat = (fallback_q > FullPower) ? FullPower : fallback_q;
  end

  // stale demand: elapsed time wraps with the time stamp
  assign elapsed = now_seconds_i - last_time_q;
  assign stale   = elapsed > TIME_W'(stale_lim_q);

  // configuration writes; unlisted indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_len_q <= CFG_TIME_W'(60);
      dead_time_q <= '0;
      invert_q    <= 1'b0;
      fallback_q  <= '0;
      stale_lim_q <= CFG_TIME_W'(120);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CYCLE_LENGTH:   cycle_len_q <= cfg_wdata_i[CFG_TIME_W-1:0];
        CFG_DEAD_TIME:      dead_time_q <= cfg_wdata_i[CFG_TIME_W-1:0];
        CFG_INVERT_DRIVE:   invert_q    <= cfg_wdata_i[0];
        CFG_FALLBACK_POWER: fallback_q  <= cfg_wdata_i[PW-1:0];
        CFG_STALE_LIMIT:    stale_lim_q <= cfg_wdata_i[CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // modulo unit: phase = now mod cycle length
  assign rem_start = in_fire && (action_i == ACTION_TICK);

  tpo_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (now_seconds_i),
    .divisor_i  (cycle_eff),
    .done_o     (rem_done),
    .rem_o      (phase)
  );

  // effective power E = P*C, plus D*(FULL - 2P) when correction applies
  assign dt_apply = (dead_time_q != '0) && (power_q != '0) && (power_q < FullPower);

  always_comb begin
    mac_en  = 1'b0;
    mac_clr = 1'b0;
    mac_a   = $signed(MA_W'(power_q));
    mac_b   = $signed(MB_W'(cycle_eff));
    case (state_q)
      ST_MUL_PC: begin
        mac_en  = 1'b1;
        mac_clr = 1'b1;
      end
      ST_MUL_DT: begin
        mac_en = dt_apply;
        mac_a  = $signed(MA_W'(FullPower)) - $signed(MA_W'(power_q) << 1);
        mac_b  = $signed(MB_W'(dead_time_q));
      end
      default: ;
    endcase
  end

  tpo_mac #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mac (
    .clk_i  (clk_i),
    .en_i   (mac_en),
    .clr_i  (mac_clr),
    .op_a_i (mac_a),
    .op_b_i (mac_b),
    .acc_o  (eff)
  );

  // wave threshold: 2p/C rising, 2(C-p)/C falling, both scaled by C*FULL
  always_comb begin
    full_scaled = $signed(AW'(cycle_eff) << FRACTION_BITS);
    rising      = ((CFG_TIME_W + 1)'(phase) << 1) < (CFG_TIME_W + 1)'(cycle_eff);
    if (rising) begin
      wave = $signed(AW'(phase) << (FRACTION_BITS + 1));
    end else begin
      wave = $signed(AW'(cycle_eff - phase) << (FRACTION_BITS + 1));
    end

    drive_next = drive_q;
    if (eff <= $signed(AW'(0))) begin
      drive_next = DRIVE_OFF;
    end else if (eff >= full_scaled) begin
      drive_next = DRIVE_ON;
    end else if (rising) begin
      // rising half may only switch off
      if (eff <= wave) begin
        drive_next = DRIVE_OFF;
      end
    end else begin
      // falling half may only switch on
      if (eff >= wave) begin
        drive_next = DRIVE_ON;
      end
    end
    drive_change = (drive_next != drive_q);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (action_i == ACTION_TICK)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          state_d = ST_MUL_PC;
        end
      end
      ST_MUL_PC: state_d = ST_MUL_DT;
      ST_MUL_DT: state_d = ST_CMP;
      ST_CMP: begin
        // hold while a pending result blocks the output register
        if (!drive_change || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      power_q     <= '0;
      last_time_q <= '0;
      drive_q     <= DRIVE_UNKNOWN;
      fb_used_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // take demand updates and the stale check at accept time
      if (in_fire) begin
        if (action_i == ACTION_SET_POWER) begin
          power_q     <= demand_sat;
          last_time_q <= now_seconds_i;
        end else begin
          fb_used_q <= stale;
          if (stale) begin
            power_q     <= fallback_sat;
            last_time_q <= now_seconds_i;
          end
        end
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // commit the new drive and load the result
      if ((state_q == ST_CMP) && drive_change && out_free) begin
        drive_q     <= drive_next;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_CMP) && drive_change && out_free) begin
      drive_level_q   <= (drive_next == DRIVE_ON) ^ invert_q;
      fallback_used_q <= fb_used_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_level_o   = drive_level_q;
  assign fallback_used_o = fallback_used_q;

endmodule
